FILE: hw/rtl/thb_pkg.sv
// shared types, sizes and codes for the heartbeat watchdog table
package thb_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam logic [2:0] OP_REGISTER  = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_HEARTBEAT = 3'd2;
  localparam logic [2:0] OP_PAUSE     = 3'd3;
  localparam logic [2:0] OP_PAUSE_ALL = 3'd4;
  localparam logic [2:0] OP_CHECK     = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DEAD      = 3'd3;
  localparam logic [2:0] ST_FAULT     = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [15:0] dead_task_id;
  } out_item_t;

  // low ID_BITS of the zero-extended 16-bit id
  function automatic logic [ID_BITS-1:0] id_from16(logic [15:0] v);
    logic [ID_BITS+15:0] t;
    t = '0;
    t[15:0] = v;
    return t[ID_BITS-1:0];
  endfunction

  function automatic logic [15:0] id_to16(logic [ID_BITS-1:0] v);
    logic [ID_BITS+15:0] t;
    t = '0;
    t[ID_BITS-1:0] = v;
    return t[15:0];
  endfunction

  function automatic logic [3:0] slot_to4(logic [SLOT_W-1:0] v);
    logic [SLOT_W+3:0] t;
    t = '0;
    t[SLOT_W-1:0] = v;
    return t[3:0];
  endfunction

endpackage

FILE: hw/rtl/thb_ram.sv
// generic single-port-write, registered-read memory
module thb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/task_heartbeat_watchdog_table_top.sv
// heartbeat watchdog table: id memory, used/alive flags and the operation sequencer
// pause all, unknown codes and checks after a fault go straight to the done state on
// acceptance; register, id lookups and check ticks step one slot per cycle first;
// one item is in work at a time
// a new item is taken once the sequencer is idle, even while the last result waits
// reset clears used, alive and fault flags at once; the id memory is not cleared
module task_heartbeat_watchdog_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  thb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output thb_pkg::out_item_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FREE = 6'b000010,
    S_FIND = 6'b000100,
    S_CHK  = 6'b001000,
    S_DEAD = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]                    op_r, op_nxt;
  logic [thb_pkg::ID_BITS-1:0]   id_r, id_nxt;
  logic [thb_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [thb_pkg::SLOT_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                          cmp_v_r, cmp_v_nxt;
  logic [thb_pkg::SLOTS-1:0]     used_r, used_nxt;
  logic [thb_pkg::SLOTS-1:0]     alive_r, alive_nxt;
  logic                          fault_r, fault_nxt;
  logic [15:0]                   fault_id_r, fault_id_nxt;
  thb_pkg::out_item_t            res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  thb_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                          wr_en;
  logic [thb_pkg::SLOT_W-1:0]    wr_addr;
  logic [thb_pkg::SLOT_W-1:0]    rd_addr;
  logic [thb_pkg::ID_BITS-1:0]   rd_data;
  logic [thb_pkg::SLOT_W-1:0]    cur;
  logic                          at_end;
  logic                          hit;

  // register writes an entry and sets its used flag in the same edge; any lookup
  // of it belongs to a later item, so the registered read never sees stale data
  thb_ram #(
    .DEPTH (thb_pkg::SLOTS),
    .WIDTH (thb_pkg::ID_BITS),
    .AW    (thb_pkg::SLOT_W)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (id_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur     = idx_r[thb_pkg::SLOT_W-1:0];
  assign at_end  = (idx_r == thb_pkg::CNT_W'(thb_pkg::SLOTS));
  assign wr_addr = cur;
  assign hit     = cmp_v_r && used_r[cmp_idx_r] && (rd_data == id_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_v_nxt     = 1'b0;
    used_nxt      = used_r;
    alive_nxt     = alive_r;
    fault_nxt     = fault_r;
    fault_id_nxt  = fault_id_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_addr       = cur;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.operation;
          id_nxt  = thb_pkg::id_from16(in_data.task_id);
          idx_nxt = '0;
          res_nxt = '0;
          case (in_data.operation)
            thb_pkg::OP_REGISTER: begin
              state_nxt = S_FREE;
            end
            thb_pkg::OP_REMOVE, thb_pkg::OP_HEARTBEAT, thb_pkg::OP_PAUSE: begin
              state_nxt = S_FIND;
            end
            thb_pkg::OP_PAUSE_ALL: begin
              // alive is only ever set on a used slot
              alive_nxt      = '0;
              res_nxt.status = (|used_r) ? thb_pkg::ST_OK : thb_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
            thb_pkg::OP_CHECK: begin
              if (fault_r) begin
                res_nxt.status       = thb_pkg::ST_FAULT;
                res_nxt.dead_task_id = fault_id_r;
                state_nxt            = S_DONE;
              end else begin
                state_nxt = S_CHK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FREE: begin
        if (at_end) begin
          res_nxt.status = thb_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else if (!used_r[cur]) begin
          wr_en              = 1'b1;
          used_nxt[cur]      = 1'b1;
          alive_nxt[cur]     = 1'b1;
          res_nxt.status     = thb_pkg::ST_OK;
          res_nxt.slot_index = thb_pkg::slot_to4(cur);
          state_nxt          = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_FIND: begin
        // read slot idx while comparing the slot read last cycle
        if (hit) begin
          case (op_r)
            thb_pkg::OP_REMOVE: begin
              used_nxt[cmp_idx_r]  = 1'b0;
              alive_nxt[cmp_idx_r] = 1'b0;
            end
            thb_pkg::OP_HEARTBEAT: alive_nxt[cmp_idx_r] = 1'b1;
            default:               alive_nxt[cmp_idx_r] = 1'b0;
          endcase
          res_nxt.status     = thb_pkg::ST_OK;
          res_nxt.slot_index = thb_pkg::slot_to4(cmp_idx_r);
          state_nxt          = S_DONE;
        end else if (at_end) begin
          res_nxt.status = thb_pkg::ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = cur;
          idx_nxt     = idx_r + 1'b1;
        end
      end

      S_CHK: begin
        if (at_end) begin
          res_nxt.status = thb_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else if (used_r[cur] && !alive_r[cur]) begin
          fault_nxt          = 1'b1;
          res_nxt.status     = thb_pkg::ST_DEAD;
          res_nxt.slot_index = thb_pkg::slot_to4(cur);
          state_nxt          = S_DEAD;
        end else begin
          alive_nxt[cur] = 1'b0;
          idx_nxt        = idx_r + 1'b1;
        end
      end

      S_DEAD: begin
        // id of the dead slot arrives from the memory this cycle
        fault_id_nxt         = thb_pkg::id_to16(rd_data);
        res_nxt.dead_task_id = thb_pkg::id_to16(rd_data);
        state_nxt            = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_v_r     <= 1'b0;
      used_r      <= '0;
      alive_r     <= '0;
      fault_r     <= 1'b0;
      fault_id_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      used_r      <= used_nxt;
      alive_r     <= alive_nxt;
      fault_r     <= fault_nxt;
      fault_id_r  <= fault_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/thb_checker.sv
// port-level checker for the heartbeat watchdog table and its bind
module thb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input thb_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == thb_pkg::ST_NOT_FOUND ||
                  out_data.status == thb_pkg::ST_FULL ||
                  out_data.status == thb_pkg::ST_FAULT) |-> out_data.slot_index == 4'd0)
    else $error("slot index set on a result with no slot");

  a_no_dead_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == thb_pkg::ST_OK ||
                  out_data.status == thb_pkg::ST_NOT_FOUND ||
                  out_data.status == thb_pkg::ST_FULL) |-> out_data.dead_task_id == 16'd0)
    else $error("dead id set on a result without a fault");

endmodule

bind task_heartbeat_watchdog_table_top thb_checker u_thb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
